@@ rtl/life_cellular_automaton_step_macros.svh @@
// assertion macros used by the top-level rtl
`ifndef LIFE_CELLULAR_AUTOMATON_STEP_MACROS_SVH
`define LIFE_CELLULAR_AUTOMATON_STEP_MACROS_SVH

// same-cycle implication
`define LCAS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LCAS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/lcas_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package lcas_pkg;

   localparam int MAX_SIDE = 32;
   localparam int POS_W    = $clog2(MAX_SIDE);
   localparam int CELL_W   = 5;
   localparam int SIZE_W   = 6;

   localparam int BIRTH_COUNT   = 3;
   localparam int SURVIVE_COUNT = 2;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   // result slots of one record, in emission order
   localparam int NUM_SLOTS = 4;
   localparam int SLOT_W    = 2;
   localparam logic [SLOT_W-1:0] SLOT_ABOVE_LEFT = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_HERE_LEFT  = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_ABOVE      = 2'd2;
   localparam logic [SLOT_W-1:0] SLOT_HERE       = 2'd3;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;
      logic [NUM_SLOTS-1:0] vals;
      logic [POS_W-1:0]     row;
      logic [POS_W-1:0]     col;
   } lcas_rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } lcas_qstat_type;

   // b3/s23 on the centre of three 3-bit rows
   function automatic logic life_rule(logic [2:0] top, logic [2:0] mid, logic [2:0] bot);
      logic [3:0] count;
      count = 4'(top[0]) + 4'(top[1]) + 4'(top[2]) + 4'(bot[0]) + 4'(bot[1])
            + 4'(bot[2]) + 4'(mid[0]) + 4'(mid[2]);
      return (count == 4'(BIRTH_COUNT)) || (mid[1] && (count == 4'(SURVIVE_COUNT)));
   endfunction

   function automatic logic [CELL_W-1:0] to_field(logic [POS_W-1:0] pos);
      return CELL_W'(pos);
   endfunction

endpackage
`default_nettype wire

@@ rtl/lcas_channels.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface lcas_req_if;
   logic valid;
   logic ready;
   logic alive;
   modport source (output valid, output alive, input ready);
   modport sink (input valid, input alive, output ready);
endinterface

interface lcas_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           next_alive;
   logic [lcas_pkg::CELL_W-1:0]    cell_row;
   logic [lcas_pkg::CELL_W-1:0]    cell_col;
   logic                           frame_last;
   modport source (output valid, output next_alive, output cell_row, output cell_col,
                   output frame_last, input ready);
   modport sink (input valid, input next_alive, input cell_row, input cell_col,
                 input frame_last, output ready);
endinterface

interface lcas_csr_if;
   logic                        valid;
   logic                        ready;
   logic [lcas_pkg::SIZE_W-1:0] grid_side;
   modport source (output valid, output grid_side, input ready);
   modport sink (input valid, input grid_side, output ready);
endinterface
`default_nettype wire

@@ rtl/life_cellular_automaton_step.sv @@
//  channel   dir  transfer payload                                  handshake
//  req_chan  in   alive                                             valid/ready
//  rsp_chan  out  next_alive, cell_row, cell_col, frame_last         valid/ready
//  csr_chan  in   grid_side                                         valid/ready
//
//  one cell accepted per clock while the record queue is not full; results leave one
//  per clock from a registered output while rsp_chan is ready; the last row gives
//  two results per input, so the 4-entry record queue fills and req_chan stalls there
//  reset is synchronous: board side 32, position (0,0), window, queue and output cleared
//  csr_chan is always ready; a write restarts the frame at (0,0)
`timescale 1ns / 1ps
`default_nettype none
`include "life_cellular_automaton_step_macros.svh"
module life_cellular_automaton_step (
   input  wire logic  clock,
   input  wire logic  reset,
   lcas_req_if.sink   req_chan,
   lcas_rsp_if.source rsp_chan,
   lcas_csr_if.sink   csr_chan
);

   logic                     push;
   logic                     pop;
   lcas_pkg::lcas_rec_type   push_rec;
   lcas_pkg::lcas_rec_type   head_rec;
   lcas_pkg::lcas_qstat_type qstat;
   logic                     rsp_last;
   logic                     rsp_on_diag;

   lcas_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .csr      (csr_chan),
      .qstat    (qstat),
      .push     (push),
      .push_rec (push_rec)
   );

   lcas_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .qstat    (qstat)
   );

   lcas_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_rec (head_rec),
      .qstat    (qstat),
      .pop      (pop),
      .rsp      (rsp_chan)
   );

   assign rsp_last    = rsp_chan.valid && rsp_chan.frame_last;
   assign rsp_on_diag = (rsp_chan.cell_row == rsp_chan.cell_col);

   `LCAS_ASSERT_NOW(a_no_push_full, clock, reset, push, !qstat.full, "push into full queue")
   `LCAS_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, !qstat.empty, "pop from empty queue")
   `LCAS_ASSERT_NOW(a_last_on_diag, clock, reset, rsp_last, rsp_on_diag, "frame_last off corner")

endmodule
`default_nettype wire

@@ rtl/lcas_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lcas_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   lcas_req_if.sink                    req,
   lcas_csr_if.sink                    csr,
   input  wire lcas_pkg::lcas_qstat_type qstat,
   output      logic                   push,
   output      lcas_pkg::lcas_rec_type push_rec
);

   localparam int POS_W = lcas_pkg::POS_W;

   logic                upper_ff  [lcas_pkg::MAX_SIDE];
   logic                middle_ff [lcas_pkg::MAX_SIDE];
   logic [2:0]          win_top_ff, win_top_in;
   logic [2:0]          win_mid_ff, win_mid_in;
   logic [2:0]          win_bot_ff, win_bot_in;
   logic [POS_W-1:0]    in_row_ff, in_row_in;
   logic [POS_W-1:0]    in_col_ff, in_col_in;
   logic [POS_W-1:0]    side_last_ff, side_last_in;

   logic                accept;
   logic                csr_write;
   logic [POS_W-1:0]    r, c;
   logic                last_row, last_col, row_ge1, col_ge1;
   logic                u, m;
   logic [2:0]          wt, wm, wb;
   logic [2:0]          wt2, wm2, wb2;
   lcas_pkg::lcas_rec_type rec;

   assign req.ready = !qstat.full;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;
   assign csr_write = csr.valid && csr.ready;

   always_comb begin
      if (csr.grid_side == '0) begin
         side_last_in = '0;
      end else if (csr.grid_side > lcas_pkg::SIZE_W'(lcas_pkg::MAX_SIDE)) begin
         side_last_in = POS_W'(lcas_pkg::MAX_SIDE - 1);
      end else begin
         side_last_in = POS_W'(csr.grid_side - 1'b1);
      end
   end

   always_comb begin
      if ((in_row_ff > side_last_ff) || (in_col_ff > side_last_ff)) begin
         r = '0;
         c = '0;
      end else begin
         r = in_row_ff;
         c = in_col_ff;
      end
      last_row = (r == side_last_ff);
      last_col = (c == side_last_ff);
      row_ge1  = (r != '0);
      col_ge1  = (c != '0);
      u = (r >= POS_W'(2)) ? upper_ff[c] : 1'b0;
      m = row_ge1 ? middle_ff[c] : 1'b0;
      if (c == '0) begin
         wt = {2'b00, u};
         wm = {2'b00, m};
         wb = {2'b00, req.alive};
      end else begin
         wt = {win_top_ff[1:0], u};
         wm = {win_mid_ff[1:0], m};
         wb = {win_bot_ff[1:0], req.alive};
      end
      wt2 = {wt[1:0], 1'b0};
      wm2 = {wm[1:0], 1'b0};
      wb2 = {wb[1:0], 1'b0};

      rec.row = r;
      rec.col = c;
      rec.mask[lcas_pkg::SLOT_ABOVE_LEFT] = col_ge1 && row_ge1;
      rec.mask[lcas_pkg::SLOT_HERE_LEFT]  = col_ge1 && last_row;
      rec.mask[lcas_pkg::SLOT_ABOVE]      = last_col && row_ge1;
      rec.mask[lcas_pkg::SLOT_HERE]       = last_col && last_row;
      rec.vals[lcas_pkg::SLOT_ABOVE_LEFT] = lcas_pkg::life_rule(wt, wm, wb);
      rec.vals[lcas_pkg::SLOT_HERE_LEFT]  = lcas_pkg::life_rule(wm, wb, 3'b000);
      rec.vals[lcas_pkg::SLOT_ABOVE]      = lcas_pkg::life_rule(wt2, wm2, wb2);
      rec.vals[lcas_pkg::SLOT_HERE]       = lcas_pkg::life_rule(wm2, wb2, 3'b000);

      win_top_in = win_top_ff;
      win_mid_in = win_mid_ff;
      win_bot_in = win_bot_ff;
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      if (csr_write) begin
         win_top_in = '0;
         win_mid_in = '0;
         win_bot_in = '0;
         in_row_in  = '0;
         in_col_in  = '0;
      end else if (accept) begin
         win_top_in = wt;
         win_mid_in = wm;
         win_bot_in = wb;
         if (last_col) begin
            in_col_in = '0;
            in_row_in = last_row ? '0 : r + 1'b1;
         end else begin
            in_col_in = c + 1'b1;
            in_row_in = r;
         end
      end
   end

   assign push     = accept && (rec.mask != '0);
   assign push_rec = rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_top_ff   <= '0;
         win_mid_ff   <= '0;
         win_bot_ff   <= '0;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         side_last_ff <= POS_W'(lcas_pkg::MAX_SIDE - 1);
      end else begin
         win_top_ff <= win_top_in;
         win_mid_ff <= win_mid_in;
         win_bot_ff <= win_bot_in;
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         if (csr_write) begin
            side_last_ff <= side_last_in;
         end
      end
   end

   // line stores, no reset: rows before the first are masked
   always_ff @(posedge clock) begin
      if (accept && !csr_write) begin
         upper_ff[c]  <= middle_ff[c];
         middle_ff[c] <= req.alive;
      end
   end

endmodule
`default_nettype wire

@@ rtl/lcas_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lcas_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire lcas_pkg::lcas_rec_type   push_rec,
   input  wire logic                     pop,
   output      lcas_pkg::lcas_rec_type   head_rec,
   output      lcas_pkg::lcas_qstat_type qstat
);

   localparam int QPTR_W = lcas_pkg::QPTR_W;
   localparam int QCNT_W = lcas_pkg::QCNT_W;

   lcas_pkg::lcas_rec_type store_ff [lcas_pkg::QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign qstat.full  = (count_ff == QCNT_W'(lcas_pkg::QDEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head_rec    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule
`default_nettype wire

@@ rtl/lcas_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lcas_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lcas_pkg::lcas_rec_type   head_rec,
   input  wire lcas_pkg::lcas_qstat_type qstat,
   output      logic                     pop,
   lcas_rsp_if.source                    rsp
);

   localparam int POS_W  = lcas_pkg::POS_W;
   localparam int CELL_W = lcas_pkg::CELL_W;
   localparam int NS     = lcas_pkg::NUM_SLOTS;

   logic [NS-1:0]        cur_mask_ff, cur_mask_in;
   logic [NS-1:0]        cur_vals_ff, cur_vals_in;
   logic [POS_W-1:0]     cur_row_ff, cur_row_in;
   logic [POS_W-1:0]     cur_col_ff, cur_col_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 next_alive_ff, next_alive_in;
   logic [CELL_W-1:0]    cell_row_ff, cell_row_in;
   logic [CELL_W-1:0]    cell_col_ff, cell_col_in;
   logic                 frame_last_ff, frame_last_in;

   logic                     step;
   logic [lcas_pkg::SLOT_W-1:0] sel;
   logic [NS-1:0]            mask_left;
   logic [POS_W-1:0]         row_above, col_left;

   assign row_above = cur_row_ff - 1'b1;
   assign col_left  = cur_col_ff - 1'b1;

   always_comb begin
      step = (!rsp_valid_ff || rsp.ready) && (cur_mask_ff != '0);

      priority if (cur_mask_ff[lcas_pkg::SLOT_ABOVE_LEFT]) begin
         sel = lcas_pkg::SLOT_ABOVE_LEFT;
      end else if (cur_mask_ff[lcas_pkg::SLOT_HERE_LEFT]) begin
         sel = lcas_pkg::SLOT_HERE_LEFT;
      end else if (cur_mask_ff[lcas_pkg::SLOT_ABOVE]) begin
         sel = lcas_pkg::SLOT_ABOVE;
      end else begin
         sel = lcas_pkg::SLOT_HERE;
      end

      mask_left = cur_mask_ff;
      if (step) begin
         mask_left[sel] = 1'b0;
      end

      pop         = (mask_left == '0) && !qstat.empty;
      cur_mask_in = mask_left;
      cur_vals_in = cur_vals_ff;
      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      if (pop) begin
         cur_mask_in = head_rec.mask;
         cur_vals_in = head_rec.vals;
         cur_row_in  = head_rec.row;
         cur_col_in  = head_rec.col;
      end

      rsp_valid_in  = step || (rsp_valid_ff && !rsp.ready);
      next_alive_in = next_alive_ff;
      cell_row_in   = cell_row_ff;
      cell_col_in   = cell_col_ff;
      frame_last_in = frame_last_ff;
      if (step) begin
         next_alive_in = cur_vals_ff[sel];
         frame_last_in = 1'b0;
         unique case (sel)
            lcas_pkg::SLOT_ABOVE_LEFT: begin
               cell_row_in = lcas_pkg::to_field(row_above);
               cell_col_in = lcas_pkg::to_field(col_left);
            end
            lcas_pkg::SLOT_HERE_LEFT: begin
               cell_row_in = lcas_pkg::to_field(cur_row_ff);
               cell_col_in = lcas_pkg::to_field(col_left);
            end
            lcas_pkg::SLOT_ABOVE: begin
               cell_row_in = lcas_pkg::to_field(row_above);
               cell_col_in = lcas_pkg::to_field(cur_col_ff);
            end
            lcas_pkg::SLOT_HERE: begin
               cell_row_in   = lcas_pkg::to_field(cur_row_ff);
               cell_col_in   = lcas_pkg::to_field(cur_col_ff);
               frame_last_in = 1'b1;
            end
            default: begin
               cell_row_in = cell_row_ff;
               cell_col_in = cell_col_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_mask_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_mask_ff  <= cur_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_vals_ff   <= cur_vals_in;
      cur_row_ff    <= cur_row_in;
      cur_col_ff    <= cur_col_in;
      next_alive_ff <= next_alive_in;
      cell_row_ff   <= cell_row_in;
      cell_col_ff   <= cell_col_in;
      frame_last_ff <= frame_last_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.next_alive = next_alive_ff;
   assign rsp.cell_row   = cell_row_ff;
   assign rsp.cell_col   = cell_col_ff;
   assign rsp.frame_last = frame_last_ff;

endmodule
`default_nettype wire
